>>> design/modbus_rtu_request_framer_unit_macros.svh
// Assertion macros for the Modbus RTU request framer.
// Included by the top level; has no other dependencies.
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_MACROS_SVH
`ifndef SYNTH
`define MBRTU_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("framer assertion failed");
`define MBRTU_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("framer assertion failed");
`else
`define MBRTU_ASSERT_SAME(label, clk, rst, cond, prop)
`define MBRTU_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> design/mbrtu_pkg.sv
// Package for the Modbus RTU request framer: request codes, the microcode
// word type, the microcode program and the CRC-16 byte update.
// It depends on nothing else.
package mbrtu_pkg;

   localparam int PC_W = 5;

   localparam logic [2:0] OP_READ_COILS     = 3'd0;
   localparam logic [2:0] OP_READ_DISCRETES = 3'd1;
   localparam logic [2:0] OP_WRITE_COILS    = 3'd2;
   localparam logic [2:0] OP_FIRMWARE       = 3'd3;
   localparam logic [2:0] OP_TEMPERATURES   = 3'd4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [PC_W-1:0] PC_READ_COILS  = 5'd0;
   localparam logic [PC_W-1:0] PC_WRITE_COILS = 5'd2;
   localparam logic [PC_W-1:0] PC_COMMON      = 5'd4;
   localparam logic [PC_W-1:0] PC_CRC_TAIL    = 5'd11;
   localparam logic [PC_W-1:0] PC_DISCRETES   = 5'd13;
   localparam logic [PC_W-1:0] PC_FIRMWARE    = 5'd19;
   localparam logic [PC_W-1:0] PC_QTY_TAIL    = 5'd23;
   localparam logic [PC_W-1:0] PC_TEMPS       = 5'd25;
   localparam logic [PC_W-1:0] PC_ERROR       = 5'd29;

   typedef enum logic [2:0] {
      SRC_CONST   = 3'd0,
      SRC_ADDR    = 3'd1,
      SRC_COIL_HI = 3'd2,
      SRC_COIL_LO = 3'd3,
      SRC_CRC_LO  = 3'd4,
      SRC_CRC_HI  = 3'd5
   } src_type;

   typedef enum logic [1:0] {
      COND_NEXT      = 2'd0,
      COND_JUMP      = 2'd1,
      COND_NOT_WRITE = 2'd2
   } cond_type;

   typedef struct packed {
      src_type         src;
      logic [7:0]      konst;
      logic            crc_en;
      logic            last;
      logic            err;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   function automatic uword_type mk(input src_type src, input logic [7:0] konst,
                                    input logic last, input logic err,
                                    input cond_type cond, input logic [PC_W-1:0] target);
      uword_type w;
      w.src    = src;
      w.konst  = konst;
      w.crc_en = (src != SRC_CRC_LO) && (src != SRC_CRC_HI);
      w.last   = last;
      w.err    = err;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Each frame has its own entry; some share the quantity bytes, all the CRC tail.
   function automatic uword_type rom_word(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         5'd0:    w = mk(SRC_ADDR,    8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd1:    w = mk(SRC_CONST,   8'h01, 1'b0, 1'b0, COND_JUMP, PC_COMMON);
         5'd2:    w = mk(SRC_ADDR,    8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd3:    w = mk(SRC_CONST,   8'h0F, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd4:    w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd5:    w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd6:    w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd7:    w = mk(SRC_CONST,   8'h0F, 1'b0, 1'b0, COND_NOT_WRITE, PC_CRC_TAIL);
         5'd8:    w = mk(SRC_CONST,   8'h02, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd9:    w = mk(SRC_COIL_HI, 8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd10:   w = mk(SRC_COIL_LO, 8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd11:   w = mk(SRC_CRC_LO,  8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd12:   w = mk(SRC_CRC_HI,  8'h00, 1'b1, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd13:   w = mk(SRC_ADDR,    8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd14:   w = mk(SRC_CONST,   8'h02, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd15:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd16:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd17:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd18:   w = mk(SRC_CONST,   8'h0C, 1'b0, 1'b0, COND_JUMP, PC_CRC_TAIL);
         5'd19:   w = mk(SRC_ADDR,    8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd20:   w = mk(SRC_CONST,   8'h04, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd21:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd22:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd23:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd24:   w = mk(SRC_CONST,   8'h02, 1'b0, 1'b0, COND_JUMP, PC_CRC_TAIL);
         5'd25:   w = mk(SRC_ADDR,    8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd26:   w = mk(SRC_CONST,   8'h04, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd27:   w = mk(SRC_CONST,   8'h00, 1'b0, 1'b0, COND_NEXT, PC_READ_COILS);
         5'd28:   w = mk(SRC_CONST,   8'h04, 1'b0, 1'b0, COND_JUMP, PC_QTY_TAIL);
         5'd29:   w = mk(SRC_CONST,   8'h00, 1'b1, 1'b1, COND_NEXT, PC_READ_COILS);
         default: w = mk(SRC_CONST,   8'h00, 1'b1, 1'b1, COND_NEXT, PC_READ_COILS);
      endcase
      return w;
   endfunction

   function automatic logic [PC_W-1:0] entry_of(input logic [2:0] opcode);
      logic [PC_W-1:0] pc;
      unique case (opcode)
         OP_READ_COILS:     pc = PC_READ_COILS;
         OP_READ_DISCRETES: pc = PC_DISCRETES;
         OP_WRITE_COILS:    pc = PC_WRITE_COILS;
         OP_FIRMWARE:       pc = PC_FIRMWARE;
         OP_TEMPERATURES:   pc = PC_TEMPS;
         default:           pc = PC_ERROR;
      endcase
      return pc;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> design/modbus_rtu_request_framer_unit.sv
// Modbus RTU request framer: a request item becomes a frame of 6 or 9 bytes plus CRC-16.
// Requests are captured in the sequencer registers; output bytes come from registers.
// A new request is stalled until the last item of the current frame has been stepped out.
// One microcode step a cycle while the output is not stalled; an unknown opcode is taken and dropped.
// Reset clears the sequencer, the output valid and link_enabled. Uses mbrtu_pkg and the macros.
module modbus_rtu_request_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_slave_address,
   input  logic [15:0] req_coil_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   output logic        rsp_link_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_link_enabled
);

`include "modbus_rtu_request_framer_unit_macros.svh"

   logic                      link_ff, link_in;
   logic                      busy_ff, busy_in;
   logic [mbrtu_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [15:0]               crc_ff, crc_in;
   logic [7:0]                addr_ff, addr_in;
   logic [15:0]               coil_ff, coil_in;
   logic                      write_ff, write_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                byte_ff, byte_in;
   logic                      last_ff, last_in;
   logic                      err_ff, err_in;

   mbrtu_pkg::uword_type      uw;
   logic                      accept;
   logic                      known;
   logic                      step;
   logic [7:0]                data;

   assign csr_ready      = 1'b1;
   assign req_stall      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;
   assign rsp_link_error = err_ff;

   assign uw     = mbrtu_pkg::rom_word(pc_ff);
   assign accept = req_valid && !busy_ff;
   assign known  = req_opcode <= mbrtu_pkg::OP_TEMPERATURES;
   assign step   = busy_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (uw.src)
         mbrtu_pkg::SRC_ADDR:    data = addr_ff;
         mbrtu_pkg::SRC_COIL_HI: data = coil_ff[15:8];
         mbrtu_pkg::SRC_COIL_LO: data = coil_ff[7:0];
         mbrtu_pkg::SRC_CRC_LO:  data = crc_ff[7:0];
         mbrtu_pkg::SRC_CRC_HI:  data = crc_ff[15:8];
         default:                data = uw.konst;
      endcase
   end

   always_comb begin
      link_in      = link_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      crc_in       = crc_ff;
      addr_in      = addr_ff;
      coil_in      = coil_ff;
      write_in     = write_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      err_in       = err_ff;

      if (csr_valid && csr_ready) begin
         link_in = csr_link_enabled;
      end

      if (accept && known) begin
         busy_in  = 1'b1;
         pc_in    = link_ff ? mbrtu_pkg::entry_of(req_opcode) : mbrtu_pkg::PC_ERROR;
         crc_in   = mbrtu_pkg::CRC_INIT;
         addr_in  = req_slave_address;
         coil_in  = req_coil_value;
         write_in = req_opcode == mbrtu_pkg::OP_WRITE_COILS;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
         byte_in      = data;
         last_in      = uw.last;
         err_in       = uw.err;
         if (uw.crc_en) begin
            crc_in = mbrtu_pkg::crc_byte(crc_ff, data);
         end
         unique case (uw.cond)
            mbrtu_pkg::COND_JUMP:      pc_in = uw.target;
            mbrtu_pkg::COND_NOT_WRITE: pc_in = write_ff ? pc_ff + 1'b1 : uw.target;
            default:                   pc_in = pc_ff + 1'b1;
         endcase
         if (uw.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= mbrtu_pkg::PC_READ_COILS;
         rsp_valid_ff <= 1'b0;
      end else begin
         link_ff      <= link_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      crc_ff   <= crc_in;
      addr_ff  <= addr_in;
      coil_ff  <= coil_in;
      write_ff <= write_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   `MBRTU_ASSERT_SAME(a_err_item_shape, clock, reset, rsp_valid_ff && err_ff, last_ff && byte_ff == 8'h00)
   `MBRTU_ASSERT_NEXT(a_last_ends_frame, clock, reset, step && uw.last, !busy_ff)
   `MBRTU_ASSERT_NEXT(a_link_down_error, clock, reset, accept && known && !link_ff, busy_ff && pc_ff == mbrtu_pkg::PC_ERROR)
   `MBRTU_ASSERT_NEXT(a_unknown_dropped, clock, reset, accept && !known, !busy_ff)

endmodule
